// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
package tcw_pkg;

  // Operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Special character bytes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [7:0] ATTR_RESET = 8'h0f;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_offset;
    logic [7:0]  read_character;
    logic [7:0]  read_attribute;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic copy;
    logic blank;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_op;
    logic scroll;
    logic copy_pend;
    logic last_copy;
    logic last_cell;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the text console writer.
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.clear_op) begin
          state_nxt = ST_CLEAR;
        end else if (sts.scroll) begin
          state_nxt = ST_COPY;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.last_copy) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        // let the last moved cell land before blanking the bottom line
        if (!sts.copy_pend) begin
          cmd.blank = 1'b1;
          if (sts.last_cell) begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_CLEAR: begin
        cmd.blank = 1'b1;
        if (sts.last_cell) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/tcw_datapath.sv
`timescale 1ns / 1ps
// Screen store, cursor registers, sweep counter and result register.
module tcw_datapath #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tcw_pkg::req_t in_req,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  tcw_pkg::cmd_t cmd,
  output tcw_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output tcw_pkg::rsp_t out_rsp
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam logic [AW-1:0] SCROLL_OFF = AW'((ROWS - 1) * COLS);

  logic [7:0]    attr_r;
  tcw_pkg::req_t req_r;
  logic          in_range_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [AW-1:0] sw_r;
  logic          copy_pend_r;
  logic [AW-1:0] copy_addr_r;
  logic [15:0]   rdres_r, rdres_nxt;
  logic          out_valid_r;
  tcw_pkg::rsp_t out_rsp_r, rsp_nxt;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_r;
  logic [AW-1:0] raddr, waddr;
  logic [15:0]   wdata;
  logic          we;
  logic          scroll;
  logic [31:0]   idx_ext;
  logic          in_range;
  logic          row_last, col_last, row_zero, col_zero;

  assign idx_ext  = 32'(in_req.cell_index);
  assign in_range = idx_ext < 32'(CELLS);

  assign row_last = (row_r == RW'(ROWS - 1));
  assign col_last = (col_r == CW'(COLS - 1));
  assign row_zero = (row_r == '0);
  assign col_zero = (col_r == '0);

  // Single read port: the scroll source while copying, otherwise the request lookup used on accept.
  assign raddr = cmd.copy ? AW'(sw_r + AW'(COLS)) : (in_range ? idx_ext[AW-1:0] : '0);

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    off_nxt   = off_r;
    rdres_nxt = rdres_r;
    we        = 1'b0;
    waddr     = sw_r;
    wdata     = {attr_r, tcw_pkg::CH_SPACE};
    scroll    = 1'b0;
    if (cmd.exec) begin
      rdres_nxt = '0;
      case (req_r.opcode)
        tcw_pkg::OP_PUT: begin
          if (req_r.char_code == tcw_pkg::CH_NEWLINE) begin
            if (row_last) begin
              scroll = 1'b1;
            end else begin
              row_nxt = row_r + RW'(1);
              col_nxt = '0;
              off_nxt = AW'({1'b0, off_r} + (AW+1)'(COLS) - (AW+1)'(col_r));
            end
          end else if (req_r.char_code == tcw_pkg::CH_BACKSPACE) begin
            we    = 1'b1;
            waddr = (row_zero && col_zero) ? off_r : off_r - AW'(1);
            if (!col_zero) begin
              col_nxt = col_r - CW'(1);
              off_nxt = off_r - AW'(1);
            end else if (!row_zero) begin
              row_nxt = row_r - RW'(1);
              col_nxt = CW'(COLS - 1);
              off_nxt = off_r - AW'(1);
            end
          end else begin
            we    = 1'b1;
            waddr = off_r;
            wdata = {attr_r, req_r.char_code};
            if (col_last) begin
              if (row_last) begin
                scroll = 1'b1;
              end else begin
                row_nxt = row_r + RW'(1);
                col_nxt = '0;
                off_nxt = off_r + AW'(1);
              end
            end else begin
              col_nxt = col_r + CW'(1);
              off_nxt = off_r + AW'(1);
            end
          end
        end
        tcw_pkg::OP_CLEAR: begin
          row_nxt = '0;
          col_nxt = '0;
          off_nxt = '0;
        end
        tcw_pkg::OP_READ: begin
          if (in_range_r) begin
            rdres_nxt = rd_r;
          end
        end
        default: begin
        end
      endcase
      if (scroll) begin
        row_nxt = RW'(ROWS - 1);
        col_nxt = '0;
        off_nxt = SCROLL_OFF;
      end
    end else if (copy_pend_r) begin
      we    = 1'b1;
      waddr = copy_addr_r;
      wdata = rd_r;
    end else if (cmd.blank) begin
      we = 1'b1;
    end
  end

  always_comb begin
    rsp_nxt.cursor_row     = 5'(row_nxt);
    rsp_nxt.cursor_column  = 7'(col_nxt);
    rsp_nxt.cursor_offset  = 11'(off_nxt);
    rsp_nxt.read_character = rdres_nxt[7:0];
    rsp_nxt.read_attribute = rdres_nxt[15:8];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r      <= in_req;
      in_range_r <= in_range;
    end
    if (cmd.copy) begin
      copy_addr_r <= sw_r;
    end
    rdres_r <= rdres_nxt;
    if (cmd.out_load) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= tcw_pkg::ATTR_RESET;
      row_r       <= '0;
      col_r       <= '0;
      off_r       <= '0;
      sw_r        <= '0;
      copy_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      off_r       <= off_nxt;
      copy_pend_r <= cmd.copy;
      if (cmd.exec) begin
        sw_r <= '0;
      end else if (cmd.copy || cmd.blank) begin
        sw_r <= sw_r + AW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clear_op  = (req_r.opcode == tcw_pkg::OP_CLEAR);
  assign sts.scroll    = scroll;
  assign sts.copy_pend = copy_pend_r;
  assign sts.last_copy = (sw_r == AW'(CELLS - COLS - 1));
  assign sts.last_cell = (sw_r == AW'(CELLS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(ROWS)) && (32'(col_r) < 32'(COLS)))
    else $error("cursor outside the screen");

  a_offset_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    32'(off_r) == 32'(row_r) * 32'(COLS) + 32'(col_r))
    else $error("linear offset out of step with row and column");

  a_copy_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    copy_pend_r |-> $past(cmd.copy))
    else $error("scroll write without a preceding scroll read");

  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !copy_pend_r && !cmd.blank)
    else $error("store write port claimed twice");

endmodule

// File: rtl/text_console_writer.sv
`timescale 1ns / 1ps
// Top level of the text console writer: request and result channels, attribute register.
// Put, read and no-op results are loaded into the result register in the execute step
// that follows acceptance, or later while that register is still full. A new request is
// taken only once the previous one has loaded its result. Scroll and clear sweep the store
// one cell per cycle via its single write port, scroll pausing for its last moved cell.
// Reset (rst_n, synchronous, active low): cursor home, attribute 0x0f; store is not cleared.
module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic          clk,
  input  logic          rst_n,
  // request channel
  input  logic          in_valid,
  output logic          in_ready,
  input  tcw_pkg::req_t in_req,
  // result channel
  output logic          out_valid,
  input  logic          out_ready,
  output tcw_pkg::rsp_t out_rsp,
  // attribute register write
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  // Sequencer: accept a request, execute it, run the store sweep for scroll
  // or clear, then hold until the result register is free.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: screen store, cursor with its linear offset, sweep counter
  // and the result register that decouples the two channels.
  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp)
  );

endmodule
